// ===== hdl/vector_unpack_format_converter_macros.svh =====
// assertion helpers used by vufc_merge
// each macro expects clk and rst_n in the scope where it is used
`ifndef VECTOR_UNPACK_FORMAT_CONVERTER_MACROS_SVH
`define VECTOR_UNPACK_FORMAT_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define VUFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vufc check failed");

// next-cycle implication, checked out of reset
`define VUFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vufc check failed");

`endif

// ===== hdl/vufc_pkg.sv =====
package vufc_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned LANE_W  = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned MASK_W  = LANES;
  localparam int unsigned IN_DW   = 2 * LANES * WORD_W;
  localparam int unsigned OUT_DW  = LANES * WORD_W;

  // unpack formats
  localparam logic [CMD_W-1:0] CMD_V4_32 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_V4_16 = 3'd1;
  localparam logic [CMD_W-1:0] CMD_V4_8  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_V3_32 = 3'd3;
  localparam logic [CMD_W-1:0] CMD_V3_16 = 3'd4;
  localparam logic [CMD_W-1:0] CMD_V2_32 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_V1_32 = 3'd6;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ZERO_EXTEND = 3'd0;
  localparam logic [IDX_W-1:0] REG_FILL_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_FILL_Z      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILL_W      = 3'd3;
  localparam logic [IDX_W-1:0] REG_WRITE_MASK  = 3'd4;

  localparam logic [WORD_W-1:0] FILL_W_RESET = 32'h3F80_0000;
  localparam logic [MASK_W-1:0] MASK_ALL     = 4'hF;

  // where a lane takes its new word from
  typedef enum logic [2:0] {
    SEL_RAW,
    SEL_W16,
    SEL_W8,
    SEL_FILL,
    SEL_OLD
  } lane_sel_t;

  typedef struct packed {
    lane_sel_t sel;
    logic      wr;
    logic      zext;
  } lane_ctl_t;

  typedef logic [LANES-1:0][WORD_W-1:0] quad_t;

  function automatic lane_sel_t lane_sel(logic [CMD_W-1:0] cmd, logic [LANE_W-1:0] lane);
    lane_sel_t s;
    unique case (cmd)
      CMD_V4_32: s = SEL_RAW;
      CMD_V4_16: s = SEL_W16;
      CMD_V4_8:  s = SEL_W8;
      CMD_V3_32: s = (lane == 2'd3) ? SEL_FILL : SEL_RAW;
      CMD_V3_16: s = (lane == 2'd3) ? SEL_FILL : SEL_W16;
      CMD_V2_32: s = (lane >= 2'd2) ? SEL_FILL : SEL_RAW;
      CMD_V1_32: s = (lane >= 2'd1) ? SEL_FILL : SEL_RAW;
      default:   s = SEL_OLD;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/vufc_lane.sv =====
module vufc_lane
  import vufc_pkg::*;
(
  input  lane_ctl_t         ctl,
  input  logic [WORD_W-1:0] src,
  input  logic [WORD_W-1:0] old,
  input  logic [WORD_W-1:0] fill,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0] nv;
  logic              ext16;
  logic              ext8;

  assign ext16 = !ctl.zext && src[15];
  assign ext8  = !ctl.zext && src[7];

  always_comb begin
    unique case (ctl.sel)
      SEL_RAW:  nv = src;
      SEL_W16:  nv = {{16{ext16}}, src[15:0]};
      SEL_W8:   nv = {{24{ext8}}, src[7:0]};
      SEL_FILL: nv = fill;
      default:  nv = old;
    endcase
  end

  // cleared mask bit keeps the previous lane
  assign res = ctl.wr ? nv : old;

endmodule

// ===== hdl/vufc_merge.sv =====
`include "vector_unpack_format_converter_macros.svh"

module vufc_merge
  import vufc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  quad_t             in_quad,
  input  logic              in_last,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast
);

  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  quad_t out_quad_r, out_quad_nxt;
  logic  out_last_r, out_last_nxt;
  quad_t skid_quad_r, skid_quad_nxt;
  logic  skid_last_r, skid_last_nxt;
  logic  accept;
  logic  drain;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign drain    = out_tready || !out_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_quad_nxt   = out_quad_r;
    out_last_nxt   = out_last_r;
    skid_quad_nxt  = skid_quad_r;
    skid_last_nxt  = skid_last_r;
    if (drain) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_quad_nxt   = skid_quad_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_quad_nxt  = in_quad;
        out_last_nxt  = in_last;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_quad_nxt  = in_quad;
      skid_last_nxt  = in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_quad_r  <= out_quad_nxt;
    out_last_r  <= out_last_nxt;
    skid_quad_r <= skid_quad_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_quad_r;
  assign out_tlast  = out_last_r;

  `VUFC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `VUFC_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid_r && !out_tready, skid_valid_r)
  `VUFC_ASSERT_NEXT(a_skid_moves_up, skid_valid_r && out_tready,
                    out_valid_r && !skid_valid_r && out_quad_r == $past(skid_quad_r))

endmodule

// ===== hdl/vector_unpack_format_converter.sv =====
// vector unpack format converter: each input transaction carries one source
// vector (up to four raw elements), an unpack format on in_tuser and the old
// destination quadword; the block widens 16- and 8-bit elements by sign or
// zero extension, fills the Y, Z and W lanes a format does not supply from
// the fill registers, and blends new and old lanes under the four-bit write
// mask, giving one 4x32 quadword per transaction. format code 7 returns the
// old quadword unchanged. while the skid stage is empty one transaction is
// taken per clock; the four lanes work side by side combinationally and the
// result is registered; the skid stage holds one more result as the consumer stalls.
// indexes beyond the list are ignored. the user writes configuration through
// cfg_we only while no transaction is in flight; the block does not enforce it.
module vector_unpack_format_converter
  import vufc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // src_a, src_b, src_c, src_d, old_x, old_y, old_z, old_w (32 bits each)
  input  logic [IN_DW-1:0]  in_tdata,
  // cmd (unpack format)
  input  logic [CMD_W-1:0]  in_tuser,
  // end_in
  input  logic              in_tlast,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_x, out_y, out_z, out_w (32 bits each)
  output logic [OUT_DW-1:0] out_tdata,
  // end_out
  output logic              out_tlast,
  // configuration writes
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [WORD_W-1:0] cfg_wdata
);

  // configuration registers
  logic              zero_extend_r;
  logic [WORD_W-1:0] fill_y_r;
  logic [WORD_W-1:0] fill_z_r;
  logic [WORD_W-1:0] fill_w_r;
  logic [MASK_W-1:0] write_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_extend_r <= 1'b0;
      fill_y_r      <= '0;
      fill_z_r      <= '0;
      fill_w_r      <= FILL_W_RESET;
      write_mask_r  <= MASK_ALL;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ZERO_EXTEND: zero_extend_r <= cfg_wdata[0];
        REG_FILL_Y:      fill_y_r      <= cfg_wdata;
        REG_FILL_Z:      fill_z_r      <= cfg_wdata;
        REG_FILL_W:      fill_w_r      <= cfg_wdata;
        REG_WRITE_MASK:  write_mask_r  <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // split the transaction into source and old lanes
  quad_t src_q;
  quad_t old_q;
  quad_t fill_q;
  quad_t res_q;

  assign src_q  = in_tdata[OUT_DW-1:0];
  assign old_q  = in_tdata[IN_DW-1:OUT_DW];
  // lane x is never filled
  assign fill_q = {fill_w_r, fill_z_r, fill_y_r, {WORD_W{1'b0}}};

  // one converter per lane, all driven by the same format code
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lane_ctl_t ctl;

    always_comb begin
      ctl.sel  = lane_sel(in_tuser, LANE_W'(g));
      ctl.wr   = write_mask_r[g] && (ctl.sel != SEL_OLD);
      ctl.zext = zero_extend_r;
    end

    vufc_lane u_lane (
      .ctl  (ctl),
      .src  (src_q[g]),
      .old  (old_q[g]),
      .fill (fill_q[g]),
      .res  (res_q[g])
    );
  end

  // gather the lanes into the output register and skid stage
  vufc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_quad    (res_q),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
